// ===== src/mhitc_pkg.sv =====
// Shared types, codes and helpers for the magic header idle timeout check.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mhitc_pkg;

    // Number of header bytes captured and compared
    localparam int MAGIC_BYTES = 4;
    localparam int FILL_W      = $clog2(MAGIC_BYTES + 1);
    localparam int CAP_IDX_W   = (MAGIC_BYTES > 1) ? $clog2(MAGIC_BYTES) : 1;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd100;
    localparam logic [CFG_W-1:0] MAGIC_RESET   = 32'h5AA5C33C;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD   = 1'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_TAKE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_VERIFY  = 2'd1,
        MODE_PENDING = 2'd2
    } mode_t;

    // One request as held in the input register
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [BYTE_W-1:0] data_byte;
        action_t           action;
    } item_t;

    // One result; verifying sits in the lowest bit
    typedef struct packed {
        logic response_ok;
        logic response_taken;
        logic response_ready;
        logic verifying;
    } result_t;

    // Expected header byte at a position; positions beyond the word compare to zero
    function automatic logic [BYTE_W-1:0] expected_byte(
        input logic [CFG_W-1:0] magic,
        input int               pos
    );
        int shift_bytes;
        shift_bytes = MAGIC_BYTES - 1 - pos;
        if (shift_bytes >= 4 || shift_bytes < 0) begin
            return '0;
        end
        return magic[shift_bytes*8 +: BYTE_W];
    endfunction

endpackage

// ===== src/mhitc_in_stage.sv =====
// Input register for the request channel of the magic header check.
// Depends on mhitc_pkg for the request type.
`timescale 1ns / 1ps

module mhitc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mhitc_pkg::item_t    s_item,
    output logic                item_valid,
    output mhitc_pkg::item_t    item,
    input  logic                item_take
);

    logic             valid_reg;
    logic             valid_next;
    mhitc_pkg::item_t item_reg;

    // Accept when empty or when the held request moves on this cycle
    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every accepted request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/mhitc_core.sv =====
// Mode machine, header capture, timeout compare and result register.
// Depends on mhitc_pkg for codes, types and the expected byte helper.
`timescale 1ns / 1ps

module mhitc_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mhitc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mhitc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                  item_valid,
    input  mhitc_pkg::item_t                      item,
    output logic                                  item_take,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output mhitc_pkg::result_t                    result
);

    localparam int MB = mhitc_pkg::MAGIC_BYTES;

    logic [mhitc_pkg::CFG_W-1:0]     timeout_reg;
    logic [mhitc_pkg::CFG_W-1:0]     magic_reg;

    mhitc_pkg::mode_t                mode_reg, mode_next;
    logic [mhitc_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                            any_reg, any_next;
    logic [mhitc_pkg::TIME_W-1:0]    last_reg, last_next;
    logic                            verdict_reg, verdict_next;
    logic [mhitc_pkg::BYTE_W-1:0]    cap_reg [MB];
    logic                            cap_we;

    logic                            out_valid_reg, out_valid_next;
    mhitc_pkg::result_t              result_reg, result_next;

    logic [mhitc_pkg::TIME_W-1:0]    elapsed;
    logic                            match;
    logic                            taken;
    logic                            taken_ok;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= mhitc_pkg::TIMEOUT_RESET;
            magic_reg   <= mhitc_pkg::MAGIC_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mhitc_pkg::REG_IDLE_TIMEOUT: timeout_reg <= cfg_wdata;
                mhitc_pkg::REG_MAGIC_WORD:   magic_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance when a request is held and the result register can take a result
    assign item_take = item_valid && (!out_valid_reg || m_tready);

    // Compare every captured byte against the header word
    always_comb begin
        match = (fill_reg >= mhitc_pkg::FILL_W'(MB));
        for (int i = 0; i < MB; i++) begin
            if (cap_reg[i] != mhitc_pkg::expected_byte(magic_reg, i)) begin
                match = 1'b0;
            end
        end
    end

    assign elapsed = item.now_ms - last_reg;

    // Next mode, capture control and result
    always_comb begin
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        any_next     = any_reg;
        last_next    = last_reg;
        verdict_next = verdict_reg;
        cap_we       = 1'b0;
        taken        = 1'b0;
        taken_ok     = 1'b0;

        case (item.action)
            mhitc_pkg::ACT_START: begin
                mode_next    = mhitc_pkg::MODE_VERIFY;
                fill_next    = '0;
                any_next     = 1'b0;
                last_next    = item.now_ms;
                verdict_next = 1'b0;
            end
            mhitc_pkg::ACT_BYTE: begin
                if (mode_reg == mhitc_pkg::MODE_VERIFY) begin
                    if (fill_reg < mhitc_pkg::FILL_W'(MB)) begin
                        cap_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    any_next  = 1'b1;
                    last_next = item.now_ms;
                end
            end
            mhitc_pkg::ACT_TICK: begin
                if (mode_reg == mhitc_pkg::MODE_VERIFY && any_reg &&
                    elapsed >= timeout_reg) begin
                    verdict_next = match;
                    mode_next    = mhitc_pkg::MODE_PENDING;
                end
            end
            mhitc_pkg::ACT_TAKE: begin
                if (mode_reg == mhitc_pkg::MODE_PENDING) begin
                    taken        = 1'b1;
                    taken_ok     = verdict_reg;
                    mode_next    = mhitc_pkg::MODE_IDLE;
                    fill_next    = '0;
                    any_next     = 1'b0;
                    verdict_next = 1'b0;
                end
            end
            default: ;
        endcase

        result_next.verifying      = (mode_next == mhitc_pkg::MODE_VERIFY);
        result_next.response_ready = (mode_next == mhitc_pkg::MODE_PENDING);
        result_next.response_taken = taken;
        if (taken) begin
            result_next.response_ok = taken_ok;
        end else if (mode_next == mhitc_pkg::MODE_PENDING) begin
            result_next.response_ok = verdict_next;
        end else begin
            result_next.response_ok = 1'b0;
        end

        // Output valid: load on advance, drop when taken
        out_valid_next = out_valid_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= mhitc_pkg::MODE_IDLE;
            fill_reg      <= '0;
            any_reg       <= 1'b0;
            last_reg      <= '0;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_take) begin
                mode_reg    <= mode_next;
                fill_reg    <= fill_next;
                any_reg     <= any_next;
                last_reg    <= last_next;
                verdict_reg <= verdict_next;
            end
        end
    end

    // Capture store and result payload
    always_ff @(posedge aclk) begin
        if (item_take && cap_we) begin
            cap_reg[fill_reg[mhitc_pkg::CAP_IDX_W-1:0]] <= item.data_byte;
        end
        if (item_take) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

// ===== src/magic_header_idle_timeout_check.sv =====
// Top level of the magic header check with idle timeout.
// Depends on mhitc_pkg, mhitc_in_stage and mhitc_core.
//
//  channel   | direction | tdata (low bit up)          | tuser
//  ----------+-----------+-----------------------------+---------------
//  s_ (req)  | in        | data_byte[7:0], now_ms[39:8]| action[1:0]
//  m_ (res)  | out       | verifying, response_ready,  | -
//            |           | response_taken, response_ok |
//  cfg_      | in        | write enable, index, data   | -
//
// One request per cycle sustained while m_tready accepts results; an accepted request
// passes the input register, then the result register.
// Reset is synchronous on aresetn low; registers return to 100 ms and 0x5AA5C33C.
// A stalled m_tready holds the result and backs up into s_tready once the
// input register is also full.
`timescale 1ns / 1ps

module magic_header_idle_timeout_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mhitc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mhitc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mhitc_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte[7:0], now_ms[39:8]
    input  logic [mhitc_pkg::ACTION_W-1:0]      s_tuser,  // action[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mhitc_pkg::M_TDATA_W-1:0]     m_tdata   // verifying, response_ready,
                                                          // response_taken, response_ok, 0
);

    mhitc_pkg::item_t   s_item;
    mhitc_pkg::item_t   item;
    logic               item_valid;
    logic               item_take;
    mhitc_pkg::result_t result;

    // Unpack the request
    assign s_item.action    = mhitc_pkg::action_t'(s_tuser);
    assign s_item.data_byte = s_tdata[mhitc_pkg::BYTE_W-1:0];
    assign s_item.now_ms    = s_tdata[mhitc_pkg::BYTE_W +: mhitc_pkg::TIME_W];

    mhitc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mhitc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    // Pack the result, zero fill to a byte
    assign m_tdata = {{(mhitc_pkg::M_TDATA_W - $bits(mhitc_pkg::result_t)){1'b0}}, result};

endmodule

// ===== src/mhitc_checker.sv =====
// Port level checks for the magic header check, bound to the top level.
// Depends on mhitc_pkg for port widths.
`timescale 1ns / 1ps

module mhitc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mhitc_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Verifying and pending never together
    a_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("verifying and response_ready both set");

    // A consumed verdict leaves the block idle
    a_taken_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
        else $error("response_taken with a non-idle mode");

    // Verdict is zero unless taken or pending
    a_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] && !m_tdata[1] |-> !m_tdata[3])
        else $error("response_ok set without a verdict");

endmodule

bind magic_header_idle_timeout_check mhitc_checker u_mhitc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_magic_header_idle_timeout_check.sv =====
// Self-checking testbench for magic_header_idle_timeout_check: a directed table, then
// random header sessions and noise under several register settings and idling patterns.
// Depends on mhitc_pkg and the RTL top; results checked against a local model or typed row.
`timescale 1ns / 1ps

module tb_magic_header_idle_timeout_check;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_wr_en;
    logic [mhitc_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [mhitc_pkg::CFG_W-1:0]          cfg_wdata;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [mhitc_pkg::S_TDATA_W-1:0]      s_tdata;   // data_byte[7:0], now_ms[39:8]
    logic [mhitc_pkg::ACTION_W-1:0]       s_tuser;   // action[1:0]
    logic                                 m_tvalid;
    logic                                 m_tready;
    // verifying, response_ready, response_taken, response_ok, pad
    logic [mhitc_pkg::M_TDATA_W-1:0]      m_tdata;

    magic_header_idle_timeout_check u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock: 2 ns period
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Header-check model state and its own register copies
    mhitc_pkg::mode_t                   hc_mode;
    logic [mhitc_pkg::BYTE_W-1:0]       hc_hdr [mhitc_pkg::MAGIC_BYTES];
    int                                 hc_fill;
    logic                               hc_got_byte;
    logic [mhitc_pkg::TIME_W-1:0]       hc_stamp;
    logic                               hc_verdict;
    logic [mhitc_pkg::CFG_W-1:0]        hc_timeout;
    logic [mhitc_pkg::CFG_W-1:0]        hc_magic;

    // Register values as the stimulus side knows them
    logic [mhitc_pkg::CFG_W-1:0]        gen_timeout;
    logic [mhitc_pkg::CFG_W-1:0]        gen_magic;

    mhitc_pkg::result_t                 verdict_queue[$];
    int                                 fault_count;
    int                                 requests_sent;
    int                                 send_idle_pct;
    int                                 recv_stall_pct;

    // Typed expectation travelling beside the request on the bus
    logic                               row_typed;
    mhitc_pkg::result_t                 row_result;

    // Directed table; result bits are {ok, taken, ready, verifying}
    typedef struct {
        mhitc_pkg::action_t           act;
        logic [mhitc_pkg::BYTE_W-1:0] dbyte;
        logic [mhitc_pkg::TIME_W-1:0] now;
        bit                           typed;
        mhitc_pkg::result_t           res;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // take, tick and byte while idle do nothing
        '{mhitc_pkg::ACT_TAKE,  8'h00, 32'd0,          1'b1, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd0,          1'b1, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'hFF, 32'd0,          1'b1, 4'b0000},
        '{mhitc_pkg::ACT_START, 8'h00, 32'd0,          1'b1, 4'b0001},
        // tick before any byte has arrived
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd1000,       1'b1, 4'b0001},
        '{mhitc_pkg::ACT_BYTE,  8'h5A, 32'd10,         1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'hA5, 32'd20,         1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'hC3, 32'd30,         1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'h3C, 32'd40,         1'b0, 4'b0000},
        // byte after the capture is full still restamps
        '{mhitc_pkg::ACT_BYTE,  8'hFF, 32'd50,         1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd149,        1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd150,        1'b1, 4'b1010},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd500,        1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TAKE,  8'h00, 32'd0,          1'b1, 4'b1100},
        // elapsed time across the 32-bit wrap
        '{mhitc_pkg::ACT_START, 8'h00, 32'hFFFF_FFF0,  1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'h00, 32'hFFFF_FFFF,  1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd63,         1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'd99,         1'b1, 4'b0010},
        // start while pending drops the verdict; take while verifying is ignored
        '{mhitc_pkg::ACT_START, 8'h00, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TAKE,  8'h00, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'h5A, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'hA5, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'hC3, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_BYTE,  8'h3D, 32'd0,          1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TICK,  8'h00, 32'hFFFF_FFFF,  1'b0, 4'b0000},
        '{mhitc_pkg::ACT_TAKE,  8'h00, 32'd0,          1'b1, 4'b0100}
    };

    task automatic log_fault(string msg);
        $display("[%0t] FAULT %s", $realtime, msg);
        fault_count++;
    endtask

    // Random payload byte
    function automatic logic [mhitc_pkg::BYTE_W-1:0] rand_byte();
        return mhitc_pkg::BYTE_W'($urandom);
    endfunction

    // Compare the captured header against the magic word, first byte most significant
    function automatic logic header_matches();
        int shift;
        logic [mhitc_pkg::BYTE_W-1:0] want;
        if (hc_fill < mhitc_pkg::MAGIC_BYTES) begin
            return 1'b0;
        end
        for (int i = 0; i < mhitc_pkg::MAGIC_BYTES; i++) begin
            shift = mhitc_pkg::MAGIC_BYTES - 1 - i;
            want  = (shift >= 4) ? '0 : hc_magic[shift*8 +: mhitc_pkg::BYTE_W];
            if (hc_hdr[i] !== want) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the header-check model by one request and return its result
    function automatic mhitc_pkg::result_t header_check_step(mhitc_pkg::item_t req);
        mhitc_pkg::result_t           res;
        logic                         taken;
        logic                         taken_ok;
        logic [mhitc_pkg::TIME_W-1:0] elapsed;
        taken    = 1'b0;
        taken_ok = 1'b0;
        elapsed  = req.now_ms - hc_stamp;
        case (req.action)
            mhitc_pkg::ACT_START: begin
                hc_mode     = mhitc_pkg::MODE_VERIFY;
                hc_fill     = 0;
                hc_got_byte = 1'b0;
                hc_stamp    = req.now_ms;
                hc_verdict  = 1'b0;
            end
            mhitc_pkg::ACT_BYTE: begin
                if (hc_mode == mhitc_pkg::MODE_VERIFY) begin
                    if (hc_fill < mhitc_pkg::MAGIC_BYTES) begin
                        hc_hdr[hc_fill] = req.data_byte;
                        hc_fill++;
                    end
                    hc_got_byte = 1'b1;
                    hc_stamp    = req.now_ms;
                end
            end
            mhitc_pkg::ACT_TICK: begin
                if (hc_mode == mhitc_pkg::MODE_VERIFY && hc_got_byte &&
                    elapsed >= hc_timeout) begin
                    hc_verdict = header_matches();
                    hc_mode    = mhitc_pkg::MODE_PENDING;
                end
            end
            default: begin
                if (hc_mode == mhitc_pkg::MODE_PENDING) begin
                    taken       = 1'b1;
                    taken_ok    = hc_verdict;
                    hc_mode     = mhitc_pkg::MODE_IDLE;
                    hc_fill     = 0;
                    hc_got_byte = 1'b0;
                    hc_verdict  = 1'b0;
                end
            end
        endcase
        res.verifying      = (hc_mode == mhitc_pkg::MODE_VERIFY);
        res.response_ready = (hc_mode == mhitc_pkg::MODE_PENDING);
        res.response_taken = taken;
        res.response_ok    = taken ? taken_ok :
                             (hc_mode == mhitc_pkg::MODE_PENDING) ? hc_verdict : 1'b0;
        return res;
    endfunction

    // Track register writes and accepted requests, check every result
    always @(posedge aclk) begin
        mhitc_pkg::item_t   req;
        mhitc_pkg::result_t want;
        mhitc_pkg::result_t got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == mhitc_pkg::REG_IDLE_TIMEOUT) begin
                    hc_timeout = cfg_wdata;
                end else if (cfg_index == mhitc_pkg::REG_MAGIC_WORD) begin
                    hc_magic = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                req.action    = mhitc_pkg::action_t'(s_tuser);
                req.data_byte = s_tdata[mhitc_pkg::BYTE_W-1:0];
                req.now_ms    = s_tdata[mhitc_pkg::BYTE_W +: mhitc_pkg::TIME_W];
                want = header_check_step(req);
                if (row_typed) begin
                    want = row_result;
                end
                verdict_queue.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = mhitc_pkg::result_t'(m_tdata[3:0]);
                if (verdict_queue.size() == 0) begin
                    log_fault($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    want = verdict_queue.pop_front();
                    if (got.verifying !== want.verifying)
                        log_fault($sformatf("verifying %b, expected %b",
                                            got.verifying, want.verifying));
                    if (got.response_ready !== want.response_ready)
                        log_fault($sformatf("response_ready %b, expected %b",
                                            got.response_ready, want.response_ready));
                    if (got.response_taken !== want.response_taken)
                        log_fault($sformatf("response_taken %b, expected %b",
                                            got.response_taken, want.response_taken));
                    if (got.response_ok !== want.response_ok)
                        log_fault($sformatf("response_ok %b, expected %b",
                                            got.response_ok, want.response_ok));
                    if (m_tdata[mhitc_pkg::M_TDATA_W-1:4] !== '0)
                        log_fault($sformatf("pad bits %h not zero",
                                            m_tdata[mhitc_pkg::M_TDATA_W-1:4]));
                end
            end
        end
    end

    // Receiver: stall at random at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one request, idling first at the current rate; hold it until accepted
    task automatic push_request(mhitc_pkg::action_t act, logic [mhitc_pkg::BYTE_W-1:0] dbyte,
                                logic [mhitc_pkg::TIME_W-1:0] now, bit typed = 1'b0,
                                mhitc_pkg::result_t res = '0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= {now, dbyte};
        row_typed  <= typed;
        row_result <= res;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
    endtask

    // Drop valid and wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(logic [mhitc_pkg::CFG_W-1:0] timeout,
                                logic [mhitc_pkg::CFG_W-1:0] magic);
        cfg_wr_en <= 1'b1;
        cfg_index <= mhitc_pkg::REG_IDLE_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_index <= mhitc_pkg::REG_MAGIC_WORD;
        cfg_wdata <= magic;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gen_timeout = timeout;
        gen_magic   = magic;
    endtask

    // One header session: start, bytes mostly matching the magic word, ticks around the deadline
    task automatic run_session();
        logic [mhitc_pkg::TIME_W-1:0] now;
        logic [mhitc_pkg::TIME_W-1:0] stamp;
        logic [mhitc_pkg::TIME_W-1:0] skew;
        logic [mhitc_pkg::BYTE_W-1:0] b;
        int                           n_bytes;
        now = $urandom;
        push_request(mhitc_pkg::ACT_START, rand_byte(), now);
        stamp   = now;
        n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : mhitc_pkg::MAGIC_BYTES;
        for (int i = 0; i < n_bytes; i++) begin
            if (i < mhitc_pkg::MAGIC_BYTES && i < 4 && $urandom_range(0, 7) != 0)
                b = gen_magic[(mhitc_pkg::MAGIC_BYTES - 1 - i)*8 +: mhitc_pkg::BYTE_W];
            else
                b = rand_byte();
            now   = now + $urandom_range(0, 20);
            stamp = now;
            push_request(mhitc_pkg::ACT_BYTE, b, now);
            // early tick, well inside the quiet time
            if ($urandom_range(0, 5) == 0)
                push_request(mhitc_pkg::ACT_TICK, rand_byte(), stamp + (gen_timeout >> 1));
        end
        repeat ($urandom_range(1, 3)) begin
            skew = $urandom_range(0, 4) - 2;
            push_request(mhitc_pkg::ACT_TICK, rand_byte(), stamp + gen_timeout + skew);
        end
        if ($urandom_range(0, 5) != 0)
            push_request(mhitc_pkg::ACT_TAKE, rand_byte(), $urandom);
    endtask

    // Mostly well-formed sessions, the rest raw requests
    task automatic run_random(int count, int pause_at);
        int target;
        target = requests_sent + count;
        while (requests_sent < target) begin
            if (pause_at > 0 && requests_sent >= pause_at) begin
                drain_results();
                pause_at = 0;
            end
            if ($urandom_range(0, 4) != 0)
                run_session();
            else
                push_request(mhitc_pkg::action_t'($urandom_range(0, 3)), rand_byte(),
                             $urandom);
        end
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_magic_header_idle_timeout_check: done, errors");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        row_typed      = 1'b0;
        row_result     = '0;
        fault_count    = 0;
        requests_sent  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hc_mode        = mhitc_pkg::MODE_IDLE;
        hc_fill        = 0;
        hc_got_byte    = 1'b0;
        hc_stamp       = '0;
        hc_verdict     = 1'b0;
        hc_timeout     = mhitc_pkg::TIMEOUT_RESET;
        hc_magic       = mhitc_pkg::MAGIC_RESET;
        gen_timeout    = mhitc_pkg::TIMEOUT_RESET;
        gen_magic      = mhitc_pkg::MAGIC_RESET;
        for (int i = 0; i < mhitc_pkg::MAGIC_BYTES; i++) hc_hdr[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at reset register values, no idling
        foreach (dir_rows[i])
            push_request(dir_rows[i].act, dir_rows[i].dbyte, dir_rows[i].now,
                         dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // Zero timeout, random magic, no idling
        program_regs('0, $urandom);
        run_random(135, 0);
        drain_results();

        // Longest timeout, zero magic, sender mostly idle
        send_idle_pct = 76;
        program_regs('1, '0);
        run_random(135, 0);
        drain_results();

        // Short timeout, all-ones magic, receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        program_regs($urandom_range(1, 300), '1);
        run_random(135, 0);
        drain_results();

        // Random registers, light idling on both sides, with a full pause midway
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        program_regs($urandom, $urandom);
        run_random(135, requests_sent + 60);
        drain_results();

        // Back to the reset register values, heavy idling on both sides
        send_idle_pct  = 76;
        recv_stall_pct = 76;
        program_regs(mhitc_pkg::TIMEOUT_RESET, mhitc_pkg::MAGIC_RESET);
        run_random(135, 0);
        drain_results();

        if (fault_count == 0)
            $display("tb_magic_header_idle_timeout_check: done, clean");
        else
            $display("tb_magic_header_idle_timeout_check: done, errors");
        $finish;
    end

endmodule
